[rtl/rs_parity_encoder_gf256_assert.svh]
// assertion macros for the parity encoder
`ifndef RS_PARITY_ENCODER_GF256_ASSERT_SVH
`define RS_PARITY_ENCODER_GF256_ASSERT_SVH
`ifndef ASSERT_OFF
`define RSPE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RSPE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RSPE_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSPE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/rspe_pkg.sv]
package rspe_pkg;

    localparam int MAX_ECC = 32;
    localparam int ECC_AW = $clog2(MAX_ECC);
    localparam int BYTE_W = 8;
    localparam int CFG_W = 6;
    localparam int CMP_W = CFG_W + 1;
    localparam logic [CFG_W-1:0] ECC_RESET = 6'd10;
    localparam logic [8:0] GF_POLY = 9'h11D;
    localparam int GF_SIZE = 256;
    localparam int GF_ORDER = 255;

    typedef logic [BYTE_W-1:0] gf_tab_t [GF_SIZE];

    function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY[7:0] : 8'h00);
    endfunction

    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] acc;
        x = a;
        acc = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

    function automatic gf_tab_t build_exp();
        gf_tab_t t;
        logic [BYTE_W-1:0] v;
        v = 8'h01;
        for (int i = 0; i < GF_ORDER; i++)
        begin
            t[i] = v;
            v = gf_xtime(v);
        end
        t[GF_ORDER] = 8'h01;
        return t;
    endfunction

    function automatic gf_tab_t build_log();
        gf_tab_t t;
        logic [BYTE_W-1:0] v;
        for (int i = 0; i < GF_SIZE; i++)
        begin
            t[i] = '0;
        end
        v = 8'h01;
        for (int i = 0; i < GF_ORDER; i++)
        begin
            t[v] = BYTE_W'(i);
            v = gf_xtime(v);
        end
        return t;
    endfunction

    localparam gf_tab_t EXP_TAB = build_exp();
    localparam gf_tab_t LOG_TAB = build_log();

    typedef enum logic [3:0] {
        ST_CLR,
        ST_BRD,
        ST_BWR,
        ST_CRD,
        ST_CWR,
        ST_IDLE,
        ST_FB,
        ST_UPD,
        ST_ERD,
        ST_ELD
    } rspe_state_t;

    typedef struct packed {
        logic              rem_rd;
        logic [ECC_AW-1:0] rem_raddr;
        logic              rem_we;
        logic [ECC_AW-1:0] rem_waddr;
        logic              rem_zero;
        logic              gen_rd;
        logic [ECC_AW-1:0] gen_raddr;
        logic              gen_we;
        logic [ECC_AW-1:0] gen_waddr;
        logic              gen_cvt;
        logic              tap_top;
        logic              carry_clr;
        logic              root_init;
        logic              root_step;
        logic              in_load;
        logic              fb_load;
        logic              out_load;
        logic              out_last;
    } rspe_ctl_t;

endpackage

[rtl/rspe_msg_if.sv]
interface rspe_msg_if;
    logic                         valid;
    logic                         ready;
    logic [rspe_pkg::BYTE_W-1:0]  data_byte;
    logic                         msg_last;

    modport source (output valid, output data_byte, output msg_last, input ready);
    modport sink (input valid, input data_byte, input msg_last, output ready);
endinterface

[rtl/rspe_par_if.sv]
interface rspe_par_if;
    logic                         valid;
    logic                         ready;
    logic [rspe_pkg::BYTE_W-1:0]  parity_byte;
    logic                         parity_last;

    modport source (output valid, output parity_byte, output parity_last, input ready);
    modport sink (input valid, input parity_byte, input parity_last, output ready);
endinterface

[rtl/rspe_datapath.sv]
module rspe_datapath (
    input  logic                        clk,
    input  rspe_pkg::rspe_ctl_t         ctl,
    input  logic [rspe_pkg::BYTE_W-1:0] data_byte,
    output logic [rspe_pkg::BYTE_W-1:0] parity_byte,
    output logic                        parity_last
);
    import rspe_pkg::*;

    logic [BYTE_W-1:0] rem_mem [MAX_ECC];
    logic [BYTE_W-1:0] gen_mem [MAX_ECC];

    logic [BYTE_W-1:0] rem_rdata_reg;
    logic [BYTE_W-1:0] gen_rdata_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] lf_reg;
    logic              fbz_reg;
    logic [BYTE_W-1:0] carry_reg;
    logic [BYTE_W-1:0] root_reg;
    logic [BYTE_W-1:0] parity_reg;
    logic              parity_last_reg;

    logic [BYTE_W-1:0] gen_old;
    logic [BYTE_W-1:0] gen_new;
    logic [BYTE_W-1:0] fb;
    logic [BYTE_W:0]   log_sum;
    logic [BYTE_W-1:0] exp_idx;
    logic [BYTE_W-1:0] term;
    logic [BYTE_W-1:0] rem_wdata;
    logic [BYTE_W-1:0] gen_wdata;

    always_comb
    begin
        // top coefficient of the monic partial generator is implicit
        gen_old = ctl.tap_top ? 8'h01 : gen_rdata_reg;
        gen_new = carry_reg ^ gf_mul(gen_old, root_reg);
        fb = data_reg ^ rem_rdata_reg;
        log_sum = {1'b0, gen_rdata_reg} + {1'b0, lf_reg};
        if (log_sum >= (BYTE_W+1)'(GF_ORDER))
        begin
            exp_idx = BYTE_W'(log_sum - (BYTE_W+1)'(GF_ORDER));
        end
        else
        begin
            exp_idx = log_sum[BYTE_W-1:0];
        end
        term = fbz_reg ? 8'h00 : EXP_TAB[exp_idx];
        rem_wdata = ctl.rem_zero ? 8'h00 : (carry_reg ^ term);
        gen_wdata = ctl.gen_cvt ? LOG_TAB[gen_rdata_reg] : gen_new;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rem_we)
        begin
            rem_mem[ctl.rem_waddr] <= rem_wdata;
        end
        if (ctl.rem_rd)
        begin
            rem_rdata_reg <= rem_mem[ctl.rem_raddr];
        end
        if (ctl.gen_we)
        begin
            gen_mem[ctl.gen_waddr] <= gen_wdata;
        end
        if (ctl.gen_rd)
        begin
            gen_rdata_reg <= gen_mem[ctl.gen_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.in_load)
        begin
            data_reg <= data_byte;
        end
        if (ctl.fb_load)
        begin
            lf_reg  <= LOG_TAB[fb];
            fbz_reg <= (fb == '0);
        end
        if (ctl.carry_clr)
        begin
            carry_reg <= '0;
        end
        else if (ctl.rem_we && !ctl.rem_zero)
        begin
            carry_reg <= rem_rdata_reg;
        end
        else if (ctl.gen_we && !ctl.gen_cvt)
        begin
            carry_reg <= gen_old;
        end
        if (ctl.root_init)
        begin
            root_reg <= 8'h01;
        end
        else if (ctl.root_step)
        begin
            root_reg <= gf_xtime(root_reg);
        end
        if (ctl.out_load)
        begin
            parity_reg      <= rem_rdata_reg;
            parity_last_reg <= ctl.out_last;
        end
    end

    assign parity_byte = parity_reg;
    assign parity_last = parity_last_reg;

endmodule

[rtl/rspe_ctrl.sv]
`include "rs_parity_encoder_gf256_assert.svh"

module rspe_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [rspe_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       msg_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rspe_pkg::rspe_ctl_t        ctl
);
    import rspe_pkg::*;

    rspe_state_t       state_reg;
    rspe_state_t       state_next;
    logic [ECC_AW-1:0] k_reg;
    logic [ECC_AW-1:0] k_next;
    logic [ECC_AW-1:0] i_reg;
    logic [ECC_AW-1:0] i_next;
    logic [CFG_W-1:0]  ecc_reg;
    logic              last_reg;
    logic              last_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ECC_AW-1:0] nm1;
    logic [ECC_AW-1:0] emit_addr;
    logic              out_free;

    always_comb
    begin
        if (ecc_reg == '0)
        begin
            nm1 = '0;
        end
        else if ({1'b0, ecc_reg} > CMP_W'(MAX_ECC))
        begin
            nm1 = ECC_AW'(MAX_ECC - 1);
        end
        else
        begin
            nm1 = ECC_AW'(ecc_reg - CFG_W'(1));
        end
    end

    assign emit_addr = nm1 - k_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            k_reg         <= '0;
            i_reg         <= '0;
            ecc_reg       <= ECC_RESET;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                state_reg <= ST_CLR;
                k_reg     <= '0;
                ecc_reg   <= cfg_wdata;
            end
            else
            begin
                state_reg <= state_next;
                k_reg     <= k_next;
            end
            i_reg         <= i_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        last_next  = last_reg;
        in_ready   = 1'b0;
        ctl        = '0;

        unique case (state_reg)
            ST_CLR:
            begin
                ctl.rem_we    = 1'b1;
                ctl.rem_waddr = k_reg;
                ctl.rem_zero  = 1'b1;
                ctl.carry_clr = 1'b1;
                ctl.root_init = 1'b1;
                if (k_reg == ECC_AW'(MAX_ECC - 1))
                begin
                    k_next     = '0;
                    i_next     = '0;
                    state_next = ST_BRD;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_BRD:
            begin
                ctl.gen_rd    = 1'b1;
                ctl.gen_raddr = k_reg;
                state_next    = ST_BWR;
            end
            ST_BWR:
            begin
                ctl.gen_we    = 1'b1;
                ctl.gen_waddr = k_reg;
                ctl.tap_top   = (k_reg == i_reg);
                if (k_reg == i_reg)
                begin
                    ctl.carry_clr = 1'b1;
                    k_next        = '0;
                    if (i_reg == nm1)
                    begin
                        state_next = ST_CRD;
                    end
                    else
                    begin
                        i_next        = i_reg + 1'b1;
                        ctl.root_step = 1'b1;
                        state_next    = ST_BRD;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_BRD;
                end
            end
            ST_CRD:
            begin
                ctl.gen_rd    = 1'b1;
                ctl.gen_raddr = k_reg;
                state_next    = ST_CWR;
            end
            ST_CWR:
            begin
                ctl.gen_we    = 1'b1;
                ctl.gen_waddr = k_reg;
                ctl.gen_cvt   = 1'b1;
                if (k_reg == nm1)
                begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_CRD;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.in_load   = 1'b1;
                    ctl.rem_rd    = 1'b1;
                    ctl.rem_raddr = nm1;
                    last_next     = msg_last;
                    state_next    = ST_FB;
                end
            end
            ST_FB:
            begin
                ctl.fb_load   = 1'b1;
                ctl.carry_clr = 1'b1;
                ctl.rem_rd    = 1'b1;
                ctl.rem_raddr = '0;
                ctl.gen_rd    = 1'b1;
                ctl.gen_raddr = '0;
                k_next        = '0;
                state_next    = ST_UPD;
            end
            ST_UPD:
            begin
                ctl.rem_we    = 1'b1;
                ctl.rem_waddr = k_reg;
                if (k_reg == nm1)
                begin
                    k_next     = '0;
                    state_next = last_reg ? ST_ERD : ST_IDLE;
                end
                else
                begin
                    ctl.rem_rd    = 1'b1;
                    ctl.rem_raddr = k_reg + 1'b1;
                    ctl.gen_rd    = 1'b1;
                    ctl.gen_raddr = k_reg + 1'b1;
                    k_next        = k_reg + 1'b1;
                end
            end
            ST_ERD:
            begin
                ctl.rem_rd    = 1'b1;
                ctl.rem_raddr = emit_addr;
                state_next    = ST_ELD;
            end
            ST_ELD:
            begin
                if (out_free)
                begin
                    ctl.out_load  = 1'b1;
                    ctl.out_last  = (k_reg == nm1);
                    ctl.rem_we    = 1'b1;
                    ctl.rem_waddr = emit_addr;
                    ctl.rem_zero  = 1'b1;
                    if (k_reg == nm1)
                    begin
                        k_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_ERD;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLR;
                k_next     = '0;
            end
        endcase

        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    `RSPE_ASSERT(a_rem_rw_clash, clk, rst_n, !(ctl.rem_we && ctl.rem_rd && (ctl.rem_waddr == ctl.rem_raddr)), "remainder read and write hit one entry")
    `RSPE_ASSERT(a_out_overrun, clk, rst_n, !ctl.out_load || !out_valid_reg || out_ready, "parity word overwritten before taken")
    `RSPE_ASSERT(a_tap_range, clk, rst_n, !((state_reg == ST_UPD) || (state_reg == ST_ERD) || (state_reg == ST_ELD)) || (k_reg <= nm1), "tap index beyond parity count")
    `RSPE_ASSERT(a_root_range, clk, rst_n, !((state_reg == ST_BRD) || (state_reg == ST_BWR)) || ((i_reg <= nm1) && (k_reg <= i_reg)), "generator build index out of range")
    `RSPE_ASSERT_NEXT(a_cfg_rebuild, clk, rst_n, cfg_we, (state_reg == ST_CLR) && (k_reg == '0) && !in_ready, "config write did not restart the rebuild")

endmodule

[rtl/rs_parity_encoder_gf256.sv]
// channel  dir  handshake     payload
// msg      in   valid/ready   data_byte[7:0], msg_last
// parity   out  valid/ready   parity_byte[7:0], parity_last
// cfg      in   cfg_we        cfg_wdata[5:0] = ecc_count
// each message word takes one read-modify-write pass over the n remainder taps
//   (n = parity count) through the log and antilog tables, one tap a cycle
// a last word then emits each parity word through ERD and ELD, waiting on parity stalls
// reset and every cfg write clear all 32 remainder entries, then rebuild the
//   generator; msg.ready stays low meanwhile
// a waiting parity word does not block the next message word
module rs_parity_encoder_gf256 (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [rspe_pkg::CFG_W-1:0] cfg_wdata,
    rspe_msg_if.sink                   msg,
    rspe_par_if.source                 parity
);
    import rspe_pkg::*;

    rspe_ctl_t ctl;

    rspe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (msg.valid),
        .in_ready  (msg.ready),
        .msg_last  (msg.msg_last),
        .out_valid (parity.valid),
        .out_ready (parity.ready),
        .ctl       (ctl)
    );

    rspe_datapath u_datapath (
        .clk         (clk),
        .ctl         (ctl),
        .data_byte   (msg.data_byte),
        .parity_byte (parity.parity_byte),
        .parity_last (parity.parity_last)
    );

endmodule

[tb/rs_parity_checker.sv]
`timescale 1ns / 100ps

module rs_parity_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [rspe_pkg::CFG_W-1:0] cfg_wdata,
    rspe_msg_if                        msg,
    rspe_par_if                        parity,
    output int                         fail_count,
    output int                         pending,
    output int                         checked
);
    import rspe_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] pbyte;
        logic              plast;
    } parity_word_t;

    logic [BYTE_W-1:0] pow_tab [GF_SIZE];
    logic [BYTE_W-1:0] log_of [GF_SIZE];
    logic [BYTE_W-1:0] rem [MAX_ECC];
    logic [BYTE_W-1:0] gen_log [MAX_ECC];
    logic [CFG_W-1:0]  count_reg;
    parity_word_t      due_parity [$];

    function automatic logic [BYTE_W-1:0] times_alpha(input logic [BYTE_W-1:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY[7:0] : 8'h00);
    endfunction

    function automatic logic [BYTE_W-1:0] field_mul(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] acc;
        x = a;
        acc = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = times_alpha(x);
        end
        return acc;
    endfunction

    function automatic int parity_count();
        if (count_reg == 0)
        begin
            return 1;
        end
        if (int'(count_reg) > MAX_ECC)
        begin
            return MAX_ECC;
        end
        return int'(count_reg);
    endfunction

    task automatic load_count(input logic [CFG_W-1:0] value);
        logic [BYTE_W-1:0] g [MAX_ECC + 1];
        logic [BYTE_W-1:0] root;
        int n;
        int k;
        count_reg = value;
        n = parity_count();
        for (k = 0; k <= MAX_ECC; k++)
        begin
            g[k] = '0;
        end
        g[0] = 8'h01;
        for (int i = 0; i < n; i++)
        begin
            root = pow_tab[i % GF_ORDER];
            for (k = i + 1; k >= 1; k--)
            begin
                g[k] = g[k - 1] ^ field_mul(g[k], root);
            end
            g[0] = field_mul(g[0], root);
        end
        for (k = 0; k < MAX_ECC; k++)
        begin
            rem[k] = '0;
            gen_log[k] = (k < n) ? log_of[g[k]] : '0;
        end
    endtask

    task automatic absorb_word(input logic [BYTE_W-1:0] d, input logic last);
        logic [BYTE_W-1:0] fb;
        parity_word_t pw;
        int n;
        int lf;
        int k;
        n = parity_count();
        fb = d ^ rem[n - 1];
        lf = int'(log_of[fb]);
        for (k = n - 1; k >= 1; k--)
        begin
            rem[k] = rem[k - 1] ^
                ((fb != 0) ? pow_tab[(int'(gen_log[k]) + lf) % GF_ORDER] : 8'h00);
        end
        rem[0] = (fb != 0) ? pow_tab[(int'(gen_log[0]) + lf) % GF_ORDER] : 8'h00;
        if (last)
        begin
            for (k = 0; k < n; k++)
            begin
                pw.pbyte = rem[n - 1 - k];
                pw.plast = (k == n - 1);
                due_parity.push_back(pw);
            end
            for (k = 0; k < MAX_ECC; k++)
            begin
                rem[k] = '0;
            end
        end
    endtask

    initial
    begin
        logic [BYTE_W-1:0] v;
        for (int i = 0; i < GF_SIZE; i++)
        begin
            log_of[i] = '0;
        end
        v = 8'h01;
        for (int i = 0; i < GF_ORDER; i++)
        begin
            pow_tab[i] = v;
            log_of[v] = BYTE_W'(i);
            v = times_alpha(v);
        end
        pow_tab[GF_ORDER] = 8'h01;
    end

    always @(posedge clk)
    begin
        parity_word_t want;
        if (!rst_n)
        begin
            load_count(ECC_RESET);
            due_parity.delete();
            fail_count = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                load_count(cfg_wdata);
            end
            if (msg.valid && msg.ready)
            begin
                absorb_word(msg.data_byte, msg.msg_last);
            end
            if (parity.valid && parity.ready)
            begin
                checked++;
                if (due_parity.size() == 0)
                begin
                    $display("%0t: unexpected parity word %02h last %0b", $time,
                             parity.parity_byte, parity.parity_last);
                    fail_count++;
                end
                else
                begin
                    want = due_parity.pop_front();
                    if (parity.parity_byte !== want.pbyte)
                    begin
                        $display("%0t: parity_byte expected %02h got %02h", $time,
                                 want.pbyte, parity.parity_byte);
                        fail_count++;
                    end
                    if (parity.parity_last !== want.plast)
                    begin
                        $display("%0t: parity_last expected %0b got %0b", $time,
                                 want.plast, parity.parity_last);
                        fail_count++;
                    end
                end
            end
        end
        pending = due_parity.size();
    end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import rspe_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 100;
    localparam int WORD_TARGET = 230;
    localparam int PHASE_WORDS = 26;
    localparam logic [CFG_W-1:0] COUNT_PLAN [8] = '{6'd1, 6'd32, 6'd0, 6'd63,
                                                    6'd33, 6'd2, 6'd17, 6'd5};

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    bit               calm;
    int               words_sent;
    int               msgs_sent;
    int               cfg_writes;
    int               idle_cycles;
    int               fail_count;
    int               pending;
    int               checked;

    rspe_msg_if msg_ch ();
    rspe_par_if par_ch ();

    rs_parity_encoder_gf256 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .msg       (msg_ch),
        .parity    (par_ch)
    );

    rs_parity_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .msg        (msg_ch),
        .parity     (par_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic send_word(input logic [BYTE_W-1:0] d, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_ch.valid <= 1'b1;
        msg_ch.data_byte <= d;
        msg_ch.msg_last <= last;
        @(posedge clk);
        while (!msg_ch.ready)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (last)
        begin
            msgs_sent++;
        end
    endtask

    task automatic send_random_message(input int len, input bit ends);
        logic [BYTE_W-1:0] d;
        for (int i = 0; i < len; i++)
        begin
            d = ($urandom_range(0, 7) == 0) ? 8'h00 : BYTE_W'($urandom_range(0, 255));
            send_word(d, ends && (i == len - 1));
        end
    endtask

    task automatic quiesce();
        msg_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] value);
        quiesce();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // parity sink with random stalls
    initial
    begin
        int stall;
        par_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                par_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            par_ch.ready <= 1'b1;
            @(posedge clk);
            while (!par_ch.valid)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (msg_ch.valid && msg_ch.ready) || (par_ch.valid && par_ch.ready)
            || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("rs_parity_encoder_gf256: mismatch");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int phase;
        int phase_start;
        int len;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= ECC_RESET;
        msg_ch.valid <= 1'b0;
        msg_ch.data_byte <= '0;
        msg_ch.msg_last <= 1'b0;
        calm = 1'b0;
        words_sent = 0;
        msgs_sent = 0;
        cfg_writes = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // single word messages at the byte extremes
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        // all zero message, feedback stays zero
        for (int i = 0; i < 4; i++)
        begin
            send_word(8'h00, i == 3);
        end
        // shorter than the parity count
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h55, 1'b1);
        // longer than the parity count
        for (int i = 0; i < 12; i++)
        begin
            send_word(BYTE_W'((i % 2) ? 8'hAA ^ i : 8'hFF - i * 17), i == 11);
        end
        // unfinished message, dropped by the next count write
        send_word(8'hC3, 1'b0);
        send_word(8'h3C, 1'b0);
        send_word(8'h7F, 1'b0);

        phase = 0;
        while (words_sent < WORD_TARGET)
        begin
            write_count((phase < 8) ? COUNT_PLAN[phase] : CFG_W'($urandom_range(0, 63)));
            calm = (phase % 3 == 1);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                send_random_message(len, 1'b1);
            end
            if ($urandom_range(0, 2) == 0)
            begin
                send_random_message($urandom_range(1, 4), 1'b0);
            end
            phase++;
        end
        calm = 1'b0;
        quiesce();

        $display("sent %0d message words in %0d messages, checked %0d parity words",
                 words_sent, msgs_sent, checked);
        $display("parity count written %0d times, covering 0, 1, 32 and saturating values",
                 cfg_writes);
        if (fail_count == 0)
        begin
            $display("rs_parity_encoder_gf256: match");
        end
        else
        begin
            $display("rs_parity_encoder_gf256: mismatch");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/rspe_pkg.sv
rtl/rspe_msg_if.sv
rtl/rspe_par_if.sv
rtl/rspe_datapath.sv
rtl/rspe_ctrl.sv
rtl/rs_parity_encoder_gf256.sv
tb/rs_parity_checker.sv
tb/tb_top.sv
